[hw/rtl/cdsu_pkg.sv]
// Shared constants, item types and address helper for the Cholesky stream unit.
package cdsu_pkg;

	localparam int MAX_N       = 8;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int ACC_W       = 64;
	localparam int IDX_W       = 3;
	localparam int SIZE_W      = 4;
	localparam int STORE_DEPTH = MAX_N * (MAX_N + 1) / 2;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	typedef struct packed {
		logic signed [DATA_W-1:0] a_value;
		logic                     start_of_matrix;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] l_value;
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic                     last_in_row;
		logic                     last_of_matrix;
		logic                     not_pos_def;
	} out_item_t;

	// packed lower-triangle address: r*(r+1)/2 + c
	function automatic logic [ADDR_W-1:0] tri_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		logic [ADDR_W:0] rr;
		logic [ADDR_W:0] prod;
		rr   = (ADDR_W+1)'(r);
		prod = (ADDR_W+1)'((rr * (rr + (ADDR_W+1)'(1))) >> 1);
		return ADDR_W'(prod + (ADDR_W+1)'(c));
	endfunction

endpackage

[hw/rtl/cdsu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cdsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/cholesky_decomposition_stream_unit.sv]
// Top level: streaming Cholesky factorization of a lower-triangle input stream.
// The lower triangle of a symmetric n x n matrix (n = configured size, 1..8;
// 0 acts as 1, above 8 as 8) arrives one item per element in row order, signed
// Q16.16. Off-diagonal items are buffered. The diagonal item (i,i) ends the
// input row and starts its computation: the unit then emits row i of L as i+1
// items, column 0 first, the diagonal last. Factor rows live in a 36-entry RAM
// with one read port, so each dot-product term takes a read, a multiply and an
// accumulate step. Per column k the dot product is followed by the shared
// iterative unit: a radix-2 divide for off-diagonal entries, a square root for
// the diagonal. Input is held off while a row is being computed; a finished
// item waits in the output register. A non-positive pivot forces zeros and
// raises not_pos_def until the matrix ends or start_of_matrix arrives.
module cholesky_decomposition_stream_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cdsu_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cdsu_pkg::out_item_t  out_item,
	input  logic                 cfg_we,
	input  logic [cdsu_pkg::SIZE_W-1:0] cfg_wdata
);

	import cdsu_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_DOT   = 10'b00_0000_0010,
		S_MUL   = 10'b00_0000_0100,
		S_ACC   = 10'b00_0000_1000,
		S_PIV   = 10'b00_0001_0000,
		S_DIFF  = 10'b00_0010_0000,
		S_SETUP = 10'b00_0100_0000,
		S_ITER  = 10'b00_1000_0000,
		S_FIN   = 10'b01_0000_0000,
		S_EMIT  = 10'b10_0000_0000
	} state_t;

	localparam int CNT_W = $clog2(ACC_W) + 1;

	function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W-1:0] s;
		s = a + b;
		if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
			s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return s;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W-1:0] s;
		s = a - b;
		if (a[ACC_W-1] != b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
			s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return s;
	endfunction

	state_t state_q;

	logic [SIZE_W-1:0] size_q;
	logic [IDX_W-1:0]  row_q, col_q;
	logic              err_q;
	logic [IDX_W-1:0]  i_q, k_q, j_q;

	// row_buffer holds the A values of the current row; cur_row the L values
	logic signed [DATA_W-1:0] row_buf_q [MAX_N];
	logic signed [DATA_W-1:0] cur_row_q [MAX_N];

	logic signed [ACC_W-1:0]  prod_q, sum_q, diff_q;
	logic signed [DATA_W-1:0] d_q;
	logic signed [DATA_W-1:0] l_q;
	logic [ACC_W-1:0]         num_q, res_q, bit_q;
	logic [DATA_W:0]          rem_q;
	logic                     neg_q;
	logic [CNT_W-1:0]         cnt_q;

	out_item_t out_q;
	logic      out_valid_q;

	// factor RAM ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	cdsu_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_factor_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(l_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// effective position of the arriving item
	logic [IDX_W-1:0] row_eff, col_eff;
	logic             err_eff;
	always_comb begin
		row_eff = in_item.start_of_matrix ? '0 : row_q;
		col_eff = (in_item.start_of_matrix || col_q > row_q) ? '0 : col_q;
		err_eff = in_item.start_of_matrix ? 1'b0 : err_q;
	end

	logic [SIZE_W-1:0] n_eff;
	logic              is_last_row;
	logic              is_diag;
	logic              out_free;
	logic              in_fire;
	always_comb begin
		if (size_q == '0) n_eff = SIZE_W'(1);
		else if (size_q > SIZE_W'(MAX_N)) n_eff = SIZE_W'(MAX_N);
		else n_eff = size_q;
		is_last_row = (SIZE_W'(i_q) + SIZE_W'(1)) >= n_eff;
		is_diag     = (k_q == i_q);
		out_free    = !out_valid_q || out_ready;
		in_ready    = (state_q == S_IDLE);
		in_fire     = in_valid && in_ready;
	end

	assign ram_raddr = (j_q < k_q) ? tri_addr(k_q, j_q) : tri_addr(k_q, k_q);
	assign ram_waddr = tri_addr(i_q, k_q);
	assign ram_we    = (state_q == S_EMIT) && out_free;

	// one step of the shared divide / square-root unit
	logic [DATA_W:0]  rem_sh;
	logic             div_ge;
	logic [ACC_W-1:0] sq_trial;
	logic             sq_ge;
	always_comb begin
		rem_sh   = {rem_q[DATA_W-1:0], num_q[ACC_W-1]};
		div_ge   = rem_sh >= {1'b0, d_q};
		sq_trial = res_q + bit_q;
		sq_ge    = num_q >= sq_trial;
	end

	// shifted A(i,k) in Q(2F)
	logic signed [ACC_W-1:0] a_ext;
	assign a_ext = {{(ACC_W-DATA_W-FRAC_BITS){row_buf_q[k_q][DATA_W-1]}},
		row_buf_q[k_q], {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					row_buf_q[col_eff] <= in_item.a_value;
				end
			end
			S_MUL: prod_q <= cur_row_q[j_q] * $signed(ram_rdata);
			S_ACC: sum_q <= sat_add(sum_q, prod_q);
			S_PIV: d_q <= $signed(ram_rdata);
			S_DIFF: diff_q <= sat_sub(a_ext, sum_q);
			S_SETUP: begin
				rem_q <= '0;
				res_q <= '0;
				bit_q <= {2'b01, {(ACC_W-2){1'b0}}};
				neg_q <= diff_q[ACC_W-1];
				if (is_diag) begin
					num_q <= diff_q[ACC_W-1] ? '0 : diff_q;
				end else begin
					num_q <= diff_q[ACC_W-1] ? -diff_q : diff_q;
				end
			end
			S_ITER: begin
				if (is_diag) begin
					if (sq_ge) begin
						num_q <= num_q - sq_trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					rem_q <= div_ge ? rem_sh - {1'b0, d_q} : rem_sh;
					num_q <= {num_q[ACC_W-2:0], div_ge};
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cur_row_q[k_q] <= l_q;
				end
			end
			default: ;
		endcase
		if (state_q == S_IDLE || (state_q == S_EMIT && out_free)) begin
			sum_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= SIZE_W'(MAX_N);
			row_q       <= '0;
			col_q       <= '0;
			err_q       <= 1'b0;
			i_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			l_q         <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			// a new item refills the output register, else a taken item empties it
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						err_q <= err_eff;
						if (col_eff < row_eff) begin
							row_q <= row_eff;
							col_q <= col_eff + IDX_W'(1);
						end else begin
							row_q   <= row_eff;
							col_q   <= '0;
							i_q     <= row_eff;
							k_q     <= '0;
							j_q     <= '0;
							state_q <= S_DOT;
						end
					end
				end
				S_DOT: begin
					// address for the RAM read is set from j and k
					if (j_q < k_q) state_q <= S_MUL;
					else if (!is_diag) state_q <= S_PIV;
					else state_q <= S_DIFF;
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					j_q     <= j_q + IDX_W'(1);
					state_q <= S_DOT;
				end
				S_PIV: state_q <= S_DIFF;
				S_DIFF: state_q <= S_SETUP;
				S_SETUP: begin
					cnt_q <= is_diag ? CNT_W'(ACC_W / 2) : CNT_W'(ACC_W);
					if (err_q || (!is_diag && d_q <= 0)) begin
						l_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_ITER;
					end
				end
				S_ITER: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) state_q <= S_FIN;
				end
				S_FIN: begin
					if (is_diag) begin
						if (res_q == '0) begin
							err_q <= 1'b1;
							l_q   <= '0;
						end else if (res_q[ACC_W-1:DATA_W-1] != '0) begin
							l_q <= {1'b0, {(DATA_W-1){1'b1}}};
						end else begin
							l_q <= res_q[DATA_W-1:0];
						end
					end else if (!neg_q) begin
						if (num_q[ACC_W-1:DATA_W-1] != '0) l_q <= {1'b0, {(DATA_W-1){1'b1}}};
						else l_q <= num_q[DATA_W-1:0];
					end else begin
						if (num_q[ACC_W-1:DATA_W-1] != '0 && num_q[ACC_W-1:0] !=
							ACC_W'({1'b1, {(DATA_W-1){1'b0}}}))
							l_q <= {1'b1, {(DATA_W-1){1'b0}}};
						else l_q <= -num_q[DATA_W-1:0];
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_q.l_value        <= l_q;
						out_q.row_index      <= i_q;
						out_q.col_index      <= k_q;
						out_q.last_in_row    <= is_diag;
						out_q.last_of_matrix <= is_diag && is_last_row;
						out_q.not_pos_def    <= err_q;
						if (is_diag) begin
							col_q   <= '0;
							state_q <= S_IDLE;
							if (is_last_row) begin
								row_q <= '0;
								err_q <= 1'b0;
							end else begin
								row_q <= i_q + IDX_W'(1);
							end
						end else begin
							k_q     <= k_q + IDX_W'(1);
							j_q     <= '0;
							state_q <= S_DOT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// a diagonal item sits on the diagonal
	a_diag_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last_in_row |-> out_item.row_index == out_item.col_index)
		else $error("diagonal item off the diagonal");

	// the matrix ends only on a diagonal item
	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last_of_matrix |-> out_item.last_in_row)
		else $error("end of matrix on an off-diagonal item");

	// column position never passes the row
	a_col_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= row_q)
		else $error("column count beyond row count");

	// a new item is taken only between rows
	a_idle_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_IDLE || (state_q == S_DOT && k_q == '0))
		else $error("item taken during row computation");

endmodule

[tb/tb_cholesky_decomposition_stream_unit.sv]
// Testbench for the streaming Cholesky unit: self-checking against a local row predictor.
`timescale 1ns / 100ps

module tb_cholesky_decomposition_stream_unit;
	import cdsu_pkg::*;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	// block ports
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	logic      cfg_we = 1'b0;
	logic [SIZE_W-1:0] cfg_wdata = '0;

	cholesky_decomposition_stream_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state: factor rows computed so far, current row, position
	logic signed [DATA_W-1:0] l_rows [STORE_DEPTH];
	logic signed [DATA_W-1:0] row_elems [MAX_N];
	int unsigned cur_row, cur_col;
	bit pivot_bad;
	logic [SIZE_W-1:0] size_reg;

	out_item_t factor_queue [$];
	int errors;
	int items_sent, results_seen;
	bit idle_on;   // random idling enabled on both sides

	localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint ACC_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

	function automatic int unsigned tri_idx(int unsigned r, int unsigned c);
		int unsigned idx;
		idx = r * (r + 1) / 2 + c;
		return (idx < STORE_DEPTH) ? idx : 0;
	endfunction

	function automatic longint add_sat(longint a, longint b);
		if (b > 0 && a > ACC_MAX - b) return ACC_MAX;
		if (b < 0 && a < ACC_MIN - b) return ACC_MIN;
		return a + b;
	endfunction

	function automatic longint sub_sat(longint a, longint b);
		if (b < 0 && a > ACC_MAX + b) return ACC_MAX;
		if (b > 0 && a < ACC_MIN + b) return ACC_MIN;
		return a - b;
	endfunction

	// floor square root of a 64-bit unsigned value, bit pair at a time
	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Feed one element to the predictor; on a diagonal push the whole factor row.
	task automatic predict_factor_row(in_item_t it);
		int unsigned n, i;
		bit last;
		longint sum, diff, q;
		longint unsigned r;
		logic signed [DATA_W-1:0] l, d;
		out_item_t o;
		n = size_reg;
		if (n < 1) n = 1;
		if (n > MAX_N) n = MAX_N;
		if (it.start_of_matrix) begin
			cur_row = 0;
			cur_col = 0;
			pivot_bad = 0;
		end
		if (cur_row >= MAX_N) cur_row = MAX_N - 1;
		if (cur_col > cur_row) cur_col = 0;
		row_elems[cur_col] = it.a_value;
		if (cur_col < cur_row) begin
			cur_col++;
			return;
		end
		i = cur_row;
		last = (i + 1 >= n);
		for (int unsigned k = 0; k <= i; k++) begin
			sum = 0;
			l = 0;
			for (int unsigned j = 0; j < k; j++)
				sum = add_sat(sum, longint'(l_rows[tri_idx(i, j)]) *
					longint'(l_rows[tri_idx(k, j)]));
			diff = sub_sat(longint'(row_elems[k]) <<< FRAC_BITS, sum);
			if (!pivot_bad) begin
				if (k == i) begin
					r = (diff > 0) ? root_floor(diff) : 0;
					if (r == 0) pivot_bad = 1;
					else l = (r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : r[31:0];
				end else begin
					d = l_rows[tri_idx(k, k)];
					if (d > 0) begin
						q = diff / longint'(d);
						if (q > 64'sh7FFF_FFFF) l = 32'sh7FFF_FFFF;
						else if (q < -64'sh8000_0000) l = 32'sh8000_0000;
						else l = q[31:0];
					end
				end
			end
			l_rows[tri_idx(i, k)] = l;
			o.l_value        = l;
			o.row_index      = i[IDX_W-1:0];
			o.col_index      = k[IDX_W-1:0];
			o.last_in_row    = (k == i);
			o.last_of_matrix = (k == i) && last;
			o.not_pos_def    = pivot_bad;
			factor_queue.push_back(o);
		end
		cur_col = 0;
		if (last) begin
			cur_row = 0;
			pivot_bad = 0;
		end else begin
			cur_row = i + 1;
		end
	endtask

	// Send one item; valid stays high until accepted and drops only while idling.
	task automatic send_item(logic signed [DATA_W-1:0] val, bit som);
		in_item_t it;
		it.a_value = val;
		it.start_of_matrix = som;
		while (idle_on && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_factor_row(it);
		items_sent++;
	endtask

	// Result side: random backpressure, check each accepted item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (factor_queue.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_item);
					errors++;
				end else if (factor_queue[0] !== out_item) begin
					$display("%0t: mismatch expected %p actual %p", $time,
						factor_queue[0], out_item);
					errors++;
					void'(factor_queue.pop_front());
				end else begin
					void'(factor_queue.pop_front());
				end
			end
			out_ready <= !(idle_on && $urandom_range(99) < 17);
		end
	end

	// Drop valid, wait until all expected results have arrived, then let the unit settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (factor_queue.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_size(int unsigned n);
		cfg_we    <= 1'b1;
		cfg_wdata <= n[SIZE_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		size_reg  = n[SIZE_W-1:0];
	endtask

	// Random symmetric positive definite matrix: A = M*M^T + diag, elements small.
	task automatic send_spd_matrix(int unsigned n, int scale);
		int m [MAX_N][MAX_N];
		longint s;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				m[r][c] = $urandom_range(2 * scale) - scale;
		for (int r = 0; r < n; r++)
			for (int c = 0; c <= r; c++) begin
				s = 0;
				for (int j = 0; j < n; j++) s += longint'(m[r][j]) * m[c][j];
				if (r == c) s += scale * scale + 1;
				send_item(s[31:0] <<< 4, (r == 0 && c == 0) ? ($urandom_range(1) == 1) : 0);
			end
	endtask

	// Directed: extremes, identity, non-positive pivots, size 0 and 15.
	task automatic test_directed();
		set_size(2);
		send_item(32'sh0001_0000, 1);           // identity 2x2
		send_item(0, 0);
		send_item(32'sh0001_0000, 0);
		send_item(32'sh7FFF_FFFF, 1);           // largest diagonal
		send_item(32'sh8000_0000, 0);           // most negative off-diagonal
		send_item(32'sh7FFF_FFFF, 0);
		send_item(0, 1);                        // zero pivot: error path
		send_item(32'sh0001_0000, 0);
		send_item(32'sh0001_0000, 0);
		send_item(32'sh8000_0000, 1);           // negative pivot
		send_item(32'sh0000_0001, 1);           // restart mid-matrix, tiny pivot
		send_item(32'sh0000_0001, 0);
		send_item(32'sh0000_0004, 0);
		drain();
		set_size(0);                            // acts as 1
		send_item(32'sh0004_0000, 0);
		send_item(-32'sd5, 1);
		drain();
		set_size(15);                           // acts as 8
		for (int r = 0; r < MAX_N; r++)
			for (int c = 0; c <= r; c++)
				send_item((r == c) ? 32'sh0010_0000 : 32'sh0000_8000, r == 0 && c == 0);
		drain();
	endtask

	// Random: mostly well-formed SPD matrices of varying size, some raw noise.
	task automatic test_random();
		int unsigned n;
		idle_on = 1;
		while (items_sent < 255) begin
			n = $urandom_range(1, MAX_N);
			if (n > 4 && $urandom_range(3) != 0) n = $urandom_range(1, 4);
			set_size(n);
			if ($urandom_range(4) == 0) begin
				for (int e = 0; e < n * (n + 1) / 2; e++)
					send_item($urandom, $urandom_range(15) == 0);
			end else begin
				send_spd_matrix(n, $urandom_range(1, 300));
			end
			drain();
		end
	endtask

	// Unthrottled stretch: back-to-back items, no output stalls.
	task automatic test_full_rate();
		idle_on = 0;
		set_size(MAX_N);
		send_spd_matrix(MAX_N, 50);
		drain();
		set_size(3);
		send_spd_matrix(3, 1000);
		send_spd_matrix(3, 7);
		drain();
	endtask

	initial begin
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		idle_on = 0;
		cur_row = 0;
		cur_col = 0;
		pivot_bad = 0;
		size_reg = 4'd8;
		foreach (l_rows[i]) l_rows[i] = '0;
		foreach (row_elems[i]) row_elems[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		out_ready <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_rate();
		test_random();
		drain();
		$display("covered %0d input items and %0d factor elements over sizes 0..15,",
			items_sent, results_seen);
		$display("including non-positive pivots, saturation and stalls");
		if (errors == 0 && factor_queue.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#80ms;
		$display("status: fail");
		$finish;
	end

endmodule
